>>> design/bwpf_pkg.sv
// Shared types and constants for the bootloader write packet framer.
package bwpf_pkg;

  localparam logic [1:0] SLOT_HEADER   = 2'd0;
  localparam logic [1:0] SLOT_DATA     = 2'd1;
  localparam logic [1:0] SLOT_CHECKSUM = 2'd2;

  localparam logic [2:0] BYTES_HEADER   = 3'd4;
  localparam logic [2:0] BYTES_DATA     = 3'd3;
  localparam logic [2:0] BYTES_CHECKSUM = 3'd1;

  localparam logic [7:0] CMD_RESET    = 8'h60;
  localparam logic [7:0] PAD_BYTE     = 8'hFF;
  // three pad bytes, modulo 256
  localparam logic [7:0] PAD_SLOT_SUM = 8'hFD;

  localparam int ADDR_W = 25;
  localparam logic [ADDR_W-1:0] ADDR_STEP = 25'd4;

  typedef struct packed {
    logic [7:0]  byte_low;
    logic [7:0]  byte_mid;
    logic [7:0]  byte_high;
    logic        start_of_chunk;
    logic [23:0] chunk_base;
    logic        end_of_chunk;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] slot_kind;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [2:0] byte_count;
    logic       last_of_run;
  } out_beat_t;

  // classified word as it waits between front and back
  typedef struct packed {
    logic [7:0]  byte_low;
    logic [7:0]  byte_mid;
    logic [7:0]  byte_high;
    logic        reload;
    logic [23:0] base;
    logic        close;
  } word_t;

endpackage

>>> design/bootloader_write_packet_framer.sv
// Top level of the bootloader write packet framer.
// Usage:
//   Input: one program word per beat on in_data, taken when push is high and
//   full is low. A two-entry queue sits in front of the slot sequencer.
//   Output: one packet slot per beat on out_data, valid while empty is low,
//   taken when pop is high. Each packet is a header slot, SLOTS_PER_PACKET
//   data or pad slots and a checksum slot; last_of_run marks the final slot
//   caused by a word.
//   cfg_wr_en / cfg_wr_data write the header command byte (reset 0x60);
//   write it only while the block is idle.
// Timing: the sequencer emits one slot per cycle into the output register while
//   that register is empty or pop is high. A word reaches the output register
//   through the sequencer, behind the header slot when it opens a packet. A word
//   yields one data slot, plus a header slot when it opens a packet and pad and
//   checksum slots when it closes one, so a packet has SLOTS_PER_PACKET + 2 slots.
// Reset: synchronous, active low; clears the queue, closes any open packet,
//   zeroes the byte address and restores the command byte.
// Stall: while pop is low with a slot waiting, the sequencer holds; the queue
//   still takes words until it fills, then full rises.
module bootloader_write_packet_framer #(
  parameter int SLOTS_PER_PACKET = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  bwpf_pkg::in_beat_t  in_data,
  output logic                empty,
  input  logic                pop,
  output bwpf_pkg::out_beat_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);

  localparam int SW = $clog2(SLOTS_PER_PACKET + 1);

  logic [7:0]      cmd_r, cmd_nxt;
  logic            head_valid;
  bwpf_pkg::word_t head;
  logic            deq;
  logic            pkt_open;
  logic [SW-1:0]   slots_filled;

  assign cmd_nxt = cfg_wr_en ? cfg_wr_data : cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= bwpf_pkg::CMD_RESET;
    end else begin
      cmd_r <= cmd_nxt;
    end
  end

  bwpf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .deq        (deq)
  );

  bwpf_back #(
    .SLOTS_PER_PACKET (SLOTS_PER_PACKET),
    .SW               (SW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .write_command (cmd_r),
    .head_valid    (head_valid),
    .head          (head),
    .deq           (deq),
    .empty         (empty),
    .pop           (pop),
    .out_data      (out_data),
    .pkt_open      (pkt_open),
    .slots_filled  (slots_filled)
  );

  a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slots_filled <= SW'(SLOTS_PER_PACKET))
    else $error("slot count past packet size");

  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !pkt_open |-> slots_filled == '0)
    else $error("closed packet with slots counted");

  a_csum_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.slot_kind == bwpf_pkg::SLOT_CHECKSUM |-> out_data.last_of_run)
    else $error("checksum slot not last of run");

  a_hdr_opens: assert property (@(posedge clk) disable iff (!rst_n)
    deq |-> pkt_open)
    else $error("word consumed with no packet open");

endmodule

>>> design/bwpf_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
module bwpf_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  bwpf_pkg::in_beat_t in_data,
  output logic             head_valid,
  output bwpf_pkg::word_t  head,
  input  logic             deq
);

  bwpf_pkg::word_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       enq;
  logic       do_deq;
  bwpf_pkg::word_t word_in;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rd_ptr_r];
  assign enq        = push && !full;
  assign do_deq     = deq && head_valid;

  always_comb begin
    word_in.byte_low  = in_data.byte_low;
    word_in.byte_mid  = in_data.byte_mid;
    word_in.byte_high = in_data.byte_high;
    word_in.reload    = in_data.start_of_chunk;
    word_in.base      = in_data.chunk_base;
    word_in.close     = in_data.end_of_chunk;
  end

  always_comb begin
    wr_ptr_nxt = enq ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_deq ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, enq} - {1'b0, do_deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= word_in;
    end
  end

endmodule

>>> design/bwpf_back.sv
// Back end: slot sequencer that emits header, data, padding and checksum slots.
module bwpf_back #(
  parameter int SLOTS_PER_PACKET = 32,
  parameter int SW = $clog2(SLOTS_PER_PACKET + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        write_command,
  input  logic              head_valid,
  input  bwpf_pkg::word_t   head,
  output logic              deq,
  output logic              empty,
  input  logic              pop,
  output bwpf_pkg::out_beat_t out_data,
  output logic              pkt_open,
  output logic [SW-1:0]     slots_filled
);

  localparam logic [1:0] ST_WORD = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_CSUM = 2'd2;
  localparam logic [SW-1:0] SLOTS_N = SW'(SLOTS_PER_PACKET);

  logic [1:0]                  state_r, state_nxt;
  logic                        open_r, open_nxt;
  logic [SW-1:0]               slots_r, slots_nxt;
  logic [7:0]                  sum_r, sum_nxt;
  logic [bwpf_pkg::ADDR_W-1:0] nba_r, nba_nxt;
  logic                        valid_r, valid_nxt;
  bwpf_pkg::out_beat_t         beat_r, beat_nxt;

  logic                        adv;
  logic                        emit;
  logic [SW-1:0]               slots_inc;
  logic [bwpf_pkg::ADDR_W-1:0] word_addr;

  assign adv          = !valid_r || pop;
  assign slots_inc    = slots_r + SW'(1);
  assign word_addr    = head.reload ? {1'b0, head.base} : nba_r;
  assign empty        = !valid_r;
  assign out_data     = beat_r;
  assign pkt_open     = open_r;
  assign slots_filled = slots_r;

  always_comb begin
    state_nxt = state_r;
    open_nxt  = open_r;
    slots_nxt = slots_r;
    sum_nxt   = sum_r;
    nba_nxt   = nba_r;
    beat_nxt  = beat_r;
    emit      = 1'b0;
    deq       = 1'b0;
    unique case (state_r)
      ST_WORD: begin
        if (head_valid && adv) begin
          emit = 1'b1;
          if (!open_r) begin
            beat_nxt.slot_kind   = bwpf_pkg::SLOT_HEADER;
            beat_nxt.out_byte0   = word_addr[8:1];
            beat_nxt.out_byte1   = word_addr[16:9];
            beat_nxt.out_byte2   = word_addr[24:17];
            beat_nxt.out_byte3   = write_command;
            beat_nxt.byte_count  = bwpf_pkg::BYTES_HEADER;
            beat_nxt.last_of_run = 1'b0;
            sum_nxt  = word_addr[8:1] + word_addr[16:9] + word_addr[24:17] + write_command;
            open_nxt = 1'b1;
            slots_nxt = '0;
            nba_nxt  = word_addr;
          end else begin
            deq = 1'b1;
            beat_nxt.slot_kind  = bwpf_pkg::SLOT_DATA;
            beat_nxt.out_byte0  = head.byte_low;
            beat_nxt.out_byte1  = head.byte_mid;
            beat_nxt.out_byte2  = head.byte_high;
            beat_nxt.out_byte3  = 8'd0;
            beat_nxt.byte_count = bwpf_pkg::BYTES_DATA;
            sum_nxt   = sum_r + head.byte_low + head.byte_mid + head.byte_high;
            slots_nxt = slots_inc;
            nba_nxt   = word_addr + bwpf_pkg::ADDR_STEP;
            if (slots_inc >= SLOTS_N) begin
              state_nxt = ST_CSUM;
              beat_nxt.last_of_run = 1'b0;
            end else if (head.close) begin
              state_nxt = ST_PAD;
              beat_nxt.last_of_run = 1'b0;
            end else begin
              beat_nxt.last_of_run = 1'b1;
            end
          end
        end
      end
      ST_PAD: begin
        if (adv) begin
          emit = 1'b1;
          beat_nxt.slot_kind   = bwpf_pkg::SLOT_DATA;
          beat_nxt.out_byte0   = bwpf_pkg::PAD_BYTE;
          beat_nxt.out_byte1   = bwpf_pkg::PAD_BYTE;
          beat_nxt.out_byte2   = bwpf_pkg::PAD_BYTE;
          beat_nxt.out_byte3   = 8'd0;
          beat_nxt.byte_count  = bwpf_pkg::BYTES_DATA;
          beat_nxt.last_of_run = 1'b0;
          sum_nxt   = sum_r + bwpf_pkg::PAD_SLOT_SUM;
          slots_nxt = slots_inc;
          nba_nxt   = nba_r + bwpf_pkg::ADDR_STEP;
          if (slots_inc >= SLOTS_N) begin
            state_nxt = ST_CSUM;
          end
        end
      end
      ST_CSUM: begin
        if (adv) begin
          emit = 1'b1;
          beat_nxt.slot_kind   = bwpf_pkg::SLOT_CHECKSUM;
          beat_nxt.out_byte0   = 8'd0 - sum_r;
          beat_nxt.out_byte1   = 8'd0;
          beat_nxt.out_byte2   = 8'd0;
          beat_nxt.out_byte3   = 8'd0;
          beat_nxt.byte_count  = bwpf_pkg::BYTES_CHECKSUM;
          beat_nxt.last_of_run = 1'b1;
          open_nxt  = 1'b0;
          slots_nxt = '0;
          sum_nxt   = 8'd0;
          state_nxt = ST_WORD;
        end
      end
      default: begin
        state_nxt = ST_WORD;
      end
    endcase
    valid_nxt = emit ? 1'b1 : (pop ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WORD;
      open_r  <= 1'b0;
      slots_r <= '0;
      sum_r   <= 8'd0;
      nba_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      open_r  <= open_nxt;
      slots_r <= slots_nxt;
      sum_r   <= sum_nxt;
      nba_r   <= nba_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

endmodule

>>> tb/bootloader_write_packet_framer_tb.sv
// Testbench for the bootloader write packet framer: random and directed words, slot scoreboard.
module bootloader_write_packet_framer_tb;

  localparam int SLOTS = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;

  class framer_predictor;
    logic [7:0]          command;
    logic                open;
    int                  filled;
    logic [7:0]          sum;
    logic [24:0]         addr;
    bwpf_pkg::out_beat_t expected_slots[$];
    int                  errors;

    function new();
      command = bwpf_pkg::CMD_RESET;
      open = 1'b0;
      filled = 0;
      sum = 8'd0;
      addr = '0;
      errors = 0;
    endfunction

    function void set_command(logic [7:0] value);
      command = value;
    endfunction

    function bwpf_pkg::out_beat_t make_slot(logic [1:0] kind, logic [7:0] b0,
                                            logic [7:0] b1, logic [7:0] b2,
                                            logic [7:0] b3, logic [2:0] cnt,
                                            logic last);
      bwpf_pkg::out_beat_t s;
      s.slot_kind = kind;
      s.out_byte0 = b0;
      s.out_byte1 = b1;
      s.out_byte2 = b2;
      s.out_byte3 = b3;
      s.byte_count = cnt;
      s.last_of_run = last;
      return s;
    endfunction

    // predict the slots one accepted word produces
    function void take_word(bwpf_pkg::in_beat_t w);
      logic [23:0] wa;
      logic        closing;
      if (w.start_of_chunk) addr = {1'b0, w.chunk_base};
      if (!open) begin
        wa = addr[24:1];
        expected_slots.push_back(make_slot(bwpf_pkg::SLOT_HEADER, wa[7:0], wa[15:8],
                                           wa[23:16], command, bwpf_pkg::BYTES_HEADER,
                                           1'b0));
        sum = wa[7:0] + wa[15:8] + wa[23:16] + command;
        open = 1'b1;
        filled = 0;
      end
      filled++;
      closing = w.end_of_chunk || filled >= SLOTS;
      expected_slots.push_back(make_slot(bwpf_pkg::SLOT_DATA, w.byte_low, w.byte_mid,
                                         w.byte_high, 8'd0, bwpf_pkg::BYTES_DATA,
                                         !closing));
      sum = sum + w.byte_low + w.byte_mid + w.byte_high;
      addr = addr + 25'd4;
      if (closing) begin
        while (filled < SLOTS) begin
          expected_slots.push_back(make_slot(bwpf_pkg::SLOT_DATA, bwpf_pkg::PAD_BYTE,
                                             bwpf_pkg::PAD_BYTE, bwpf_pkg::PAD_BYTE,
                                             8'd0, bwpf_pkg::BYTES_DATA, 1'b0));
          sum = sum + bwpf_pkg::PAD_BYTE + bwpf_pkg::PAD_BYTE + bwpf_pkg::PAD_BYTE;
          filled++;
          addr = addr + 25'd4;
        end
        expected_slots.push_back(make_slot(bwpf_pkg::SLOT_CHECKSUM, 8'd0 - sum, 8'd0,
                                           8'd0, 8'd0, bwpf_pkg::BYTES_CHECKSUM, 1'b1));
        open = 1'b0;
        filled = 0;
        sum = 8'd0;
      end
    endfunction

    function void compare(string field, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want_v, got_v);
      end
    endfunction

    function void check_slot(bwpf_pkg::out_beat_t got);
      bwpf_pkg::out_beat_t want;
      if (expected_slots.size() == 0) begin
        errors++;
        $display("%0t: unexpected slot: expected none, got %h", $time, got);
        return;
      end
      want = expected_slots.pop_front();
      compare("slot_kind", 32'(want.slot_kind), 32'(got.slot_kind));
      compare("out_byte0", 32'(want.out_byte0), 32'(got.out_byte0));
      compare("out_byte1", 32'(want.out_byte1), 32'(got.out_byte1));
      compare("out_byte2", 32'(want.out_byte2), 32'(got.out_byte2));
      compare("out_byte3", 32'(want.out_byte3), 32'(got.out_byte3));
      compare("byte_count", 32'(want.byte_count), 32'(got.byte_count));
      compare("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                push;
  logic                full;
  bwpf_pkg::in_beat_t  in_data;
  logic                empty;
  logic                pop;
  bwpf_pkg::out_beat_t out_data;
  logic                cfg_wr_en;
  logic [7:0]          cfg_wr_data;

  framer_predictor model;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int cycles;

  bootloader_write_packet_framer #(
    .SLOTS_PER_PACKET(SLOTS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_data(in_data),
    .empty(empty),
    .pop(pop),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side: sample the beat taken at this edge, then pick next pop
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (pop && !empty) model.check_slot(out_data);
        if (hold_cycles > 0) begin
          hold_cycles--;
          pop <= 1'b0;
        end else begin
          pop <= ($urandom_range(99) >= recv_stall_pct);
        end
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic bwpf_pkg::in_beat_t make_word(logic start, logic [23:0] base,
                                                   logic stop);
    bwpf_pkg::in_beat_t w;
    w.byte_low = rand_byte();
    w.byte_mid = rand_byte();
    w.byte_high = rand_byte();
    w.start_of_chunk = start;
    w.chunk_base = base;
    w.end_of_chunk = stop;
    return w;
  endfunction

  task automatic send_word(bwpf_pkg::in_beat_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (full);
    model.take_word(w);
  endtask

  task automatic write_command(logic [7:0] value);
    push <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model.set_command(value);
  endtask

  function automatic logic [23:0] rand_base();
    case ($urandom_range(3))
      0: return 24'($urandom_range(255)) << 2;
      1: return 24'hFFFFFF - 24'($urandom_range(300));
      default: return 24'($urandom);
    endcase
  endfunction

  // mostly whole chunks with random content, some stray or broken words
  task automatic send_chunks(int n_words);
    int sent;
    int len;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(5))
          0: len = SLOTS;
          1: len = 2 * SLOTS + $urandom_range(3);
          2: len = $urandom_range(70, 33);
          default: len = $urandom_range(12, 1);
        endcase
        if (len > n_words - sent) len = n_words - sent;
        for (int i = 0; i < len; i++)
          send_word(make_word(i == 0, (i == 0) ? rand_base() : 24'($urandom),
                              i == len - 1));
        sent += len;
      end else begin
        send_word(make_word(1'($urandom_range(1)), rand_base(), 1'($urandom_range(1))));
        sent++;
      end
    end
  endtask

  task automatic directed_words();
    bwpf_pkg::in_beat_t w;
    w = make_word(1'b1, 24'h000000, 1'b0);
    w.byte_low = 8'h00; w.byte_mid = 8'h00; w.byte_high = 8'h00;
    send_word(w);
    w = make_word(1'b0, 24'hFFFFFF, 1'b1);
    w.byte_low = 8'hFF; w.byte_mid = 8'hFF; w.byte_high = 8'hFF;
    send_word(w);
    // no start while closed: header from the padded address
    w = make_word(1'b0, 24'h000000, 1'b0);
    w.byte_low = 8'hA5; w.byte_mid = 8'h5A; w.byte_high = 8'h3C;
    send_word(w);
    // start inside an open packet reloads the address for the next header
    w = make_word(1'b1, 24'hFFFFFF, 1'b1);
    w.byte_low = 8'h01; w.byte_mid = 8'h80; w.byte_high = 8'h7F;
    send_word(w);
    // header with address bit 24 set
    send_word(make_word(1'b0, 24'h123456, 1'b1));
    send_word(make_word(1'b1, 24'hFFFFFE, 1'b1));
    send_word(make_word(1'b1, 24'h000001, 1'b1));
    send_word(make_word(1'b1, 24'hAAAAAA, 1'b0));
    send_word(make_word(1'b1, 24'h555555, 1'b0));
    send_word(make_word(1'b0, 24'h000000, 1'b0));
    send_word(make_word(1'b0, 24'hFFFFFF, 1'b1));
    send_word(make_word(1'b0, 24'h000000, 1'b1));
  endtask

  initial begin
    model = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    push = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_words();
    send_chunks(50);

    write_command(8'h00);
    send_idle_pct = 83;
    send_chunks(80);

    write_command(8'hFF);
    send_idle_pct = 0;
    recv_stall_pct = 83;
    send_chunks(80);

    write_command(8'($urandom_range(255)));
    send_idle_pct = 24;
    recv_stall_pct = 24;
    send_chunks(80);

    // long receiver hold-off while words keep coming
    write_command(bwpf_pkg::CMD_RESET);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 300;
    send_chunks(60);

    write_command(8'($urandom_range(255)));
    send_chunks(60);

    push <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (model.pending() != 0) model.errors++;
    if (model.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
